### hdl/ckrt_pkg.sv
// Shared constants and types for the compacting keyed record table.
package ckrt_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int KeyW = 32;
    localparam int PayW = 16 + 48 + 24;
    localparam int EntW = KeyW + PayW;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_EXISTS = 3'd3;
    localparam logic [2:0] ACT_LIST   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ZEROKEY  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef logic [EntW-1:0] entry_t;

    // Memory port bundle from the sequencer to the record store.
    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] waddr;
        entry_t          wdata;
        logic [IdxW-1:0] raddr;
    } mem_req_t;

endpackage

### hdl/ckrt_store.sv
// Record store: one write port, one registered read port.
module ckrt_store
    import ckrt_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t mem [TableDepth];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

### hdl/compacting_keyed_record_table_top.sv
// Top level of the compacting keyed record table.
//
// The table holds up to 16 records packed at the front of one synchronous
// memory with a registered read port. Each request is handled alone: a
// sequencer walks the stored entries one per cycle, reading slot i while
// comparing the data read for slot i-1. A match ends the walk of a lookup
// or an add early. A delete walks to the match and then moves each later
// entry down one slot (read next, write current). A list reads each stored
// entry and then loads it into the output register. Output stalls hold the
// sequencer: each result waits in the output register until it is taken,
// and the next request is accepted only once that register is free.
// s_axis_tdata fields from bit 0 up: action[3], record_key[32], year_in[16],
// course_a_in[16], grade_a_in[8], course_b_in[16], grade_b_in[8],
// course_c_in[16], grade_c_in[8], zero fill to 128 bits.
// m_axis_tdata fields from bit 0 up: status[3], key_out[32], year_out[16],
// course_a_out[16], grade_a_out[8], course_b_out[16], grade_b_out[8],
// course_c_out[16], grade_c_out[8], used_count[5], 128 bits in all.
// m_axis_tlast is last_result.
module compacting_keyed_record_table_top
    import ckrt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // action,key,year,ca,ga,cb,gb,cc,gc
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // status,key,year,ca,ga,cb,gb,cc,gc,count
    output logic         m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_LIST, S_EMIT
    } state_t;

    state_t          state_reg;
    logic [2:0]      act_reg;
    logic [KeyW-1:0] key_reg;
    logic [PayW-1:0] pay_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] idx_reg;     // slot being read this cycle
    logic            rd_vld_reg;  // memory data valid for slot idx_reg-1
    logic            ovalid_reg;
    logic [127:0]    odata_reg;
    logic            olast_reg;

    mem_req_t req;
    entry_t   rdata;

    ckrt_store u_store (.aclk(aclk), .req(req), .rdata(rdata));

    logic [IdxW-1:0] idx_lo;
    logic [CntW-1:0] prev_idx;
    logic            hit;
    logic            out_free;
    logic            out_load;
    logic            add_ok;
    logic [2:0]      s_act;
    assign idx_lo   = idx_reg[IdxW-1:0];
    assign prev_idx = idx_reg - CntW'(1);
    assign hit      = rd_vld_reg && (rdata[KeyW-1:0] == key_reg);
    assign out_free = !ovalid_reg || m_axis_tready;
    assign add_ok   = (count_reg != CntW'(TableDepth)) && (key_reg != '0) && !hit;
    assign s_act    = s_axis_tdata[2:0];
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;

    // Load the output register this cycle.
    assign out_load = (s_axis_tvalid && s_axis_tready && s_act == ACT_LIST &&
                       count_reg == '0) ||
                      (state_reg == S_LIST && rd_vld_reg && out_free) ||
                      (state_reg == S_EMIT && out_free);

    // Drive the memory port.
    always_comb begin
        req.we    = 1'b0;
        req.waddr = idx_lo;
        req.wdata = rdata;
        req.raddr = idx_lo;
        if ((state_reg == S_LIST && rd_vld_reg) ||
            (state_reg == S_SCAN && hit && act_reg != ACT_DELETE)) begin
            // Hold the read on the slot being presented or matched.
            req.raddr = prev_idx[IdxW-1:0];
        end
        if (state_reg == S_EMIT && act_reg == ACT_ADD && add_ok && out_free) begin
            req.we    = 1'b1;
            req.waddr = count_reg[IdxW-1:0];
            req.wdata = {pay_reg, key_reg};
        end else if (state_reg == S_SHIFT && rd_vld_reg) begin
            req.we    = 1'b1;
            req.waddr = IdxW'(prev_idx - CntW'(1));
        end
    end

    function automatic logic [127:0] pack_res(logic [2:0] st, entry_t e,
                                              logic [CntW-1:0] cnt);
        return {5'(cnt), e, st};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            if (out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    rd_vld_reg <= 1'b0;
                    idx_reg    <= '0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        act_reg <= s_act;
                        key_reg <= s_axis_tdata[34:3];
                        pay_reg <= s_axis_tdata[122:35];
                        if (s_act == ACT_LIST) begin
                            if (count_reg == '0) begin
                                odata_reg  <= pack_res(ST_EMPTY, '0, count_reg);
                                olast_reg  <= 1'b1;
                            end else begin
                                state_reg <= S_LIST;
                            end
                        end else if (s_act == ACT_ADD || s_act == ACT_DELETE ||
                                     s_act == ACT_READ || s_act == ACT_EXISTS) begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Compare previous slot while reading the next one.
                    if (hit) begin
                        if (act_reg == ACT_DELETE) begin
                            state_reg  <= S_SHIFT;
                            idx_reg    <= idx_reg + CntW'(1);
                            rd_vld_reg <= (idx_reg < count_reg);
                        end else begin
                            state_reg <= S_EMIT;
                            idx_reg   <= prev_idx;
                        end
                    end else if (idx_reg >= count_reg) begin
                        state_reg <= S_EMIT;
                        rd_vld_reg <= 1'b0;
                    end else begin
                        idx_reg    <= idx_reg + CntW'(1);
                        rd_vld_reg <= 1'b1;
                    end
                end
                S_SHIFT: begin
                    // Move each later entry down one slot.
                    if (idx_reg > count_reg || idx_reg == CntW'(TableDepth)
                        && !rd_vld_reg) begin
                        state_reg <= S_EMIT;
                    end else if (idx_reg >= count_reg) begin
                        rd_vld_reg <= 1'b1;
                        idx_reg    <= idx_reg + CntW'(1);
                        if (rd_vld_reg) state_reg <= S_EMIT;
                    end else begin
                        idx_reg    <= idx_reg + CntW'(1);
                        rd_vld_reg <= 1'b1;
                    end
                end
                S_LIST: begin
                    if (rd_vld_reg) begin
                        if (out_free) begin
                            odata_reg  <= pack_res(ST_OK, rdata, count_reg);
                            olast_reg  <= (idx_reg == count_reg);
                            if (idx_reg == count_reg) begin
                                state_reg <= S_IDLE;
                            end
                            rd_vld_reg <= 1'b0;
                        end
                    end else begin
                        idx_reg    <= idx_reg + CntW'(1);
                        rd_vld_reg <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg  <= S_IDLE;
                        olast_reg  <= 1'b1;
                        unique case (act_reg)
                            ACT_ADD: begin
                                if (count_reg == CntW'(TableDepth)) begin
                                    odata_reg <= pack_res(ST_FULL, '0, count_reg);
                                end else if (key_reg == '0) begin
                                    odata_reg <= pack_res(ST_ZEROKEY, '0, count_reg);
                                end else if (hit) begin
                                    odata_reg <= pack_res(ST_DUP, '0, count_reg);
                                end else begin
                                    count_reg <= count_reg + CntW'(1);
                                    odata_reg <= pack_res(ST_OK, '0,
                                                          count_reg + CntW'(1));
                                end
                            end
                            ACT_DELETE: begin
                                if (idx_reg > count_reg || rd_vld_reg) begin
                                    count_reg <= count_reg - CntW'(1);
                                    odata_reg <= pack_res(ST_OK, '0,
                                                          count_reg - CntW'(1));
                                end else begin
                                    odata_reg <= pack_res(ST_NOTFOUND, '0, count_reg);
                                end
                            end
                            default: begin
                                if (hit) begin
                                    odata_reg <= pack_res(ST_OK, rdata, count_reg);
                                end else begin
                                    odata_reg <= pack_res(ST_NOTFOUND, '0, count_reg);
                                end
                            end
                        endcase
                        rd_vld_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

### tb/ckrt_checker.sv
// Checker for the record table: predicts results from accepted requests and compares them.
module ckrt_checker
    import ckrt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key;
        logic [15:0] year;
        logic [15:0] course_a;
        logic [7:0]  grade_a;
        logic [15:0] course_b;
        logic [7:0]  grade_b;
        logic [15:0] course_c;
        logic [7:0]  grade_c;
        logic [4:0]  used;
        logic        last;
    } reply_t;

    logic [31:0] tbl_key [TableDepth];
    logic [87:0] tbl_pay [TableDepth];   // year, ca, ga, cb, gb, cc, gc from bit 0
    int          tbl_count;
    reply_t      reply_queue[$];

    assign pending_results = reply_queue.size();

    function automatic int lookup(input logic [31:0] key);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_key[i] == key) return i;
        return -1;
    endfunction

    function automatic reply_t make_reply(input logic [2:0] st, input int slot,
                                          input logic last);
        reply_t r;
        r = '0;
        r.status = st;
        if (slot >= 0) begin
            r.key      = tbl_key[slot];
            r.year     = tbl_pay[slot][15:0];
            r.course_a = tbl_pay[slot][31:16];
            r.grade_a  = tbl_pay[slot][39:32];
            r.course_b = tbl_pay[slot][55:40];
            r.grade_b  = tbl_pay[slot][63:56];
            r.course_c = tbl_pay[slot][79:64];
            r.grade_c  = tbl_pay[slot][87:80];
        end
        r.used = tbl_count[4:0];
        r.last = last;
        return r;
    endfunction

    task automatic predict_request(input logic [127:0] d);
        logic [2:0]  act;
        logic [31:0] key;
        int          slot;
        act  = d[2:0];
        key  = d[34:3];
        slot = lookup(key);
        case (act) inside
            ACT_ADD: begin
                if (tbl_count >= TableDepth)
                    reply_queue.push_back(make_reply(ST_FULL, -1, 1'b1));
                else if (key == 0)
                    reply_queue.push_back(make_reply(ST_ZEROKEY, -1, 1'b1));
                else if (slot >= 0)
                    reply_queue.push_back(make_reply(ST_DUP, -1, 1'b1));
                else begin
                    tbl_key[tbl_count] = key;
                    tbl_pay[tbl_count] = d[122:35];
                    tbl_count++;
                    reply_queue.push_back(make_reply(ST_OK, -1, 1'b1));
                end
            end
            ACT_DELETE: begin
                if (slot < 0) reply_queue.push_back(make_reply(ST_NOTFOUND, -1, 1'b1));
                else begin
                    for (int i = slot; i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_pay[i] = tbl_pay[i+1];
                    end
                    tbl_count--;
                    reply_queue.push_back(make_reply(ST_OK, -1, 1'b1));
                end
            end
            ACT_READ, ACT_EXISTS:
                reply_queue.push_back(make_reply(slot >= 0 ? ST_OK : ST_NOTFOUND,
                                                 slot, 1'b1));
            ACT_LIST: begin
                if (tbl_count == 0) reply_queue.push_back(make_reply(ST_EMPTY, -1, 1'b1));
                else for (int i = 0; i < tbl_count; i++)
                    reply_queue.push_back(make_reply(ST_OK, i, i + 1 == tbl_count));
            end
            default: ;  // drop unknown actions
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t e;
        if (!aresetn) begin
            tbl_count  <= 0;
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_queue.size() == 0) begin
                    $error("unexpected result %0h", m_axis_tdata);
                    fail_count++;
                end else begin
                    e = reply_queue.pop_front();
                    compare_field("status", 32'(e.status), 32'(m_axis_tdata[2:0]));
                    compare_field("key_out", e.key, m_axis_tdata[34:3]);
                    compare_field("year_out", 32'(e.year), 32'(m_axis_tdata[50:35]));
                    compare_field("course_a_out", 32'(e.course_a),
                                  32'(m_axis_tdata[66:51]));
                    compare_field("grade_a_out", 32'(e.grade_a),
                                  32'(m_axis_tdata[74:67]));
                    compare_field("course_b_out", 32'(e.course_b),
                                  32'(m_axis_tdata[90:75]));
                    compare_field("grade_b_out", 32'(e.grade_b),
                                  32'(m_axis_tdata[98:91]));
                    compare_field("course_c_out", 32'(e.course_c),
                                  32'(m_axis_tdata[114:99]));
                    compare_field("grade_c_out", 32'(e.grade_c),
                                  32'(m_axis_tdata[122:115]));
                    compare_field("used_count", 32'(e.used), 32'(m_axis_tdata[127:123]));
                    compare_field("last_result", 32'(e.last), 32'(m_axis_tlast));
                end
            end
        end
    end
endmodule

### tb/testbench.sv
// Top of the record table testbench: clock, reset, request stimulus and verdict.
module testbench
    import ckrt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending_results;
    int           idle_cycles = 0;
    logic [31:0]  key_pool [8];

    always #5 aclk = ~aclk;

    compacting_keyed_record_table_top DUT (.*);

    ckrt_checker u_checker (.*);

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one request; hold it until the handshake completes.
    // Drop valid only when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(input logic [2:0] act, input logic [31:0] key,
                                input logic [87:0] pay);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= {5'd0, pay, key, act};
        s_axis_tvalid <= 1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    function automatic logic [87:0] rand_pay();
        return 88'({$urandom, $urandom, $urandom});
    endfunction

    // Receiver stalls at random.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 30) == 0);
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        logic [2:0] act;
        int         r;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'd1;

        // Directed: empty-table cases, zero key, extremes, duplicates, full.
        send_request(ACT_LIST, 0, '0);
        send_request(ACT_READ, 5, '0);
        send_request(ACT_DELETE, 0, '0);
        send_request(ACT_ADD, 0, rand_pay());
        send_request(ACT_ADD, 32'hFFFF_FFFF, '1);
        send_request(ACT_ADD, 32'd1, '0);
        send_request(ACT_ADD, 32'd1, rand_pay());
        send_request(ACT_EXISTS, 32'hFFFF_FFFF, '0);
        send_request(ACT_READ, 32'd1, '0);
        send_request(3'd5, 32'd1, '0);
        send_request(3'd7, 32'd9, '1);
        for (int i = 2; i < 16; i++) send_request(ACT_ADD, 32'h100 + i, rand_pay());
        send_request(ACT_ADD, 32'h777, rand_pay());
        send_request(ACT_LIST, 0, '0);
        send_request(ACT_DELETE, 32'h10F, '0);
        send_request(ACT_DELETE, 32'hFFFF_FFFF, '0);
        send_request(ACT_DELETE, 32'h107, '0);
        send_request(ACT_LIST, 0, '0);

        // Hold off until every outstanding result has drained.
        s_axis_tvalid <= 0;
        wait (pending_results == 0);
        for (int i = 0; i < 14; i++) send_request(ACT_DELETE, 32'h100 + i, '0);
        send_request(ACT_LIST, 0, '0);

        // Random part: keys mostly from a small pool so hits are common.
        for (int n = 0; n < 105; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) act = ACT_ADD;
            else if (r < 60) act = ACT_DELETE;
            else if (r < 75) act = ACT_READ;
            else if (r < 87) act = ACT_EXISTS;
            else if (r < 96) act = ACT_LIST;
            else act = 3'($urandom_range(5, 7));
            r = $urandom_range(0, 99);
            send_request(act, r < 80 ? key_pool[$urandom_range(0, 7)]
                              : (r < 85 ? 32'd0 : $urandom), rand_pay());
            if ($urandom_range(0, 40) == 0) key_pool[$urandom_range(2, 7)] = $urandom;
        end

        s_axis_tvalid <= 0;
        wait (pending_results == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
